// ===== design/config_language_tokenizer_top_macros.svh =====
// ----------------------------------------------------------------------------
// config_language_tokenizer_top_macros
// Assertion macros shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`ifndef CONFIG_LANGUAGE_TOKENIZER_TOP_MACROS_SVH
`define CONFIG_LANGUAGE_TOKENIZER_TOP_MACROS_SVH

// condition holds at every edge out of reset
`define CLT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define CLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/clt_pkg.sv =====
// ----------------------------------------------------------------------------
// clt_pkg
// Types, codes and helper functions of the configuration language tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [3:0] KIND_IDENT    = 4'd0;
  localparam logic [3:0] KIND_NUMBER   = 4'd1;
  localparam logic [3:0] KIND_STRING   = 4'd2;
  localparam logic [3:0] KIND_COLON    = 4'd3;
  localparam logic [3:0] KIND_LBRACE   = 4'd4;
  localparam logic [3:0] KIND_RBRACE   = 4'd5;
  localparam logic [3:0] KIND_LBRACKET = 4'd6;
  localparam logic [3:0] KIND_RBRACKET = 4'd7;
  localparam logic [3:0] KIND_COMMA    = 4'd8;
  localparam logic [3:0] KIND_EOF      = 4'd9;
  localparam logic [3:0] KIND_ERROR    = 4'd10;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_UNTERM     = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_IDENT   = 3'd2,
    MODE_NUMBER  = 3'd3,
    MODE_STRING  = 3'd4,
    MODE_DONE    = 3'd5
  } clt_mode_t;

  typedef enum logic [3:0] {
    CL_SPACE   = 4'd0,  // space, tab, CR
    CL_NEWLINE = 4'd1,
    CL_HASH    = 4'd2,
    CL_IDSTART = 4'd3,  // letter, '_', '-', '='
    CL_DIGIT   = 4'd4,
    CL_PLUS    = 4'd5,  // only valid inside an identifier
    CL_QUOTE   = 4'd6,
    CL_PUNCT   = 4'd7,
    CL_OTHER   = 4'd8
  } clt_class_t;

  typedef struct packed {
    logic       op;
    logic [7:0] source_byte;
  } clt_in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [1:0]  error_kind;
    logic [7:0]  bad_byte;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [31:0] text_offset;
    logic [15:0] text_length;
    logic        last;
  } clt_out_t;

  // queue entry between front and back
  typedef struct packed {
    logic       op;
    logic [7:0] source_byte;
    clt_class_t cls;
    logic [3:0] punct_kind;
  } clt_item_t;

  function automatic logic [15:0] sat16_inc(input logic [15:0] v);
    sat16_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [31:0] sat32_inc(input logic [31:0] v);
    sat32_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic logic [15:0] sub_floor16(input logic [15:0] a, input logic [15:0] b);
    sub_floor16 = (a >= b) ? a - b : 16'd0;
  endfunction

  function automatic clt_out_t mk_res(input logic [3:0] kind, input logic [1:0] err,
                                      input logic [7:0] bad, input logic [15:0] line,
                                      input logic [15:0] col, input logic [31:0] off,
                                      input logic [15:0] len);
    clt_out_t r;
    r.token_kind   = kind;
    r.error_kind   = err;
    r.bad_byte     = bad;
    r.token_line   = line;
    r.token_column = col;
    r.text_offset  = off;
    r.text_length  = len;
    r.last         = 1'b0;
    mk_res = r;
  endfunction

endpackage

// ===== design/clt_front.sv =====
// ----------------------------------------------------------------------------
// clt_front
// Input side: takes source transactions and classifies each byte.
// ----------------------------------------------------------------------------
module clt_front
  import clt_pkg::*;
(
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  clt_in_t   in_data,
  input  logic      q_full,
  output logic      q_push,
  output clt_item_t q_item
);

  logic [7:0] c;
  logic       is_alpha;

  assign c        = in_data.source_byte;
  assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  // in_ready stays low while in reset
  assign in_ready = !q_full && rst_n;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    q_item.op          = in_data.op;
    q_item.source_byte = c;
    q_item.punct_kind  = KIND_ERROR;
    q_item.cls         = CL_OTHER;
    if (c == 8'h20 || c == 8'h09 || c == 8'h0D) begin
      q_item.cls = CL_SPACE;
    end else if (c == 8'h0A) begin
      q_item.cls = CL_NEWLINE;
    end else if (c == "#") begin
      q_item.cls = CL_HASH;
    end else if (is_alpha || c == "_" || c == "-" || c == "=") begin
      q_item.cls = CL_IDSTART;
    end else if (c >= "0" && c <= "9") begin
      q_item.cls = CL_DIGIT;
    end else if (c == "+") begin
      q_item.cls = CL_PLUS;
    end else if (c == 8'h22) begin
      q_item.cls = CL_QUOTE;
    end else begin
      case (c)
        ":": begin q_item.cls = CL_PUNCT; q_item.punct_kind = KIND_COLON; end
        "{": begin q_item.cls = CL_PUNCT; q_item.punct_kind = KIND_LBRACE; end
        "}": begin q_item.cls = CL_PUNCT; q_item.punct_kind = KIND_RBRACE; end
        "[": begin q_item.cls = CL_PUNCT; q_item.punct_kind = KIND_LBRACKET; end
        "]": begin q_item.cls = CL_PUNCT; q_item.punct_kind = KIND_RBRACKET; end
        ",": begin q_item.cls = CL_PUNCT; q_item.punct_kind = KIND_COMMA; end
        default: q_item.cls = CL_OTHER;
      endcase
    end
  end

endmodule

// ===== design/clt_fifo.sv =====
// ----------------------------------------------------------------------------
// clt_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`include "config_language_tokenizer_top_macros.svh"

module clt_fifo
  import clt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  clt_item_t push_item,
  input  logic      pop,
  output clt_item_t head_item,
  output logic      full,
  output logic      empty
);

  clt_item_t        mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] count_r, count_nxt;

  assign full      = (count_r == QCntW'(QDepth));
  assign empty     = (count_r == '0);
  assign head_item = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  `CLT_ASSERT_ALWAYS(a_no_push_full, !(push && full && !pop), "push into full queue")
  `CLT_ASSERT_ALWAYS(a_no_pop_empty, !(pop && empty), "pop from empty queue")
  `CLT_ASSERT_ALWAYS(a_count_range, count_r <= QCntW'(QDepth), "queue count out of range")

endmodule

// ===== design/clt_back.sv =====
// ----------------------------------------------------------------------------
// clt_back
// Scanner: runs the token state machine on queued items and drives results.
// ----------------------------------------------------------------------------
`include "config_language_tokenizer_top_macros.svh"

module clt_back
  import clt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  clt_item_t q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output clt_out_t  out_data
);

  clt_mode_t   mode_r, mode_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] col_r, col_nxt;
  logic [31:0] off_r, off_nxt;
  logic [31:0] tstart_r, tstart_nxt;
  logic [15:0] tlen_r, tlen_nxt;

  logic        out_valid_r, out_valid_nxt;
  clt_out_t    out_r, out_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  clt_out_t    pend_r, pend_nxt;

  logic        can_load;
  clt_out_t    r0, r1;
  logic [1:0]  n_res;

  // scratch for the step
  logic        do_idle, flush_hit, idle_emit, ident_more;
  logic [3:0]  flush_kind;
  logic [15:0] col_inc;
  logic [31:0] off_inc;
  clt_out_t    flush_res, idle_res, eof_res;

  assign can_load  = !out_valid_r || out_ready;
  assign q_pop     = !q_empty && !pend_valid_r && can_load;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    mode_nxt   = mode_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    off_nxt    = off_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    do_idle    = 1'b0;
    flush_hit  = 1'b0;
    idle_emit  = 1'b0;
    r0         = '0;
    r1         = '0;
    n_res      = 2'd0;
    col_inc    = sat16_inc(col_r);
    off_inc    = sat32_inc(off_r);
    ident_more = (q_item.cls == CL_IDSTART) || (q_item.cls == CL_DIGIT)
              || (q_item.cls == CL_PLUS);
    flush_kind = (mode_r == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER;
    flush_res  = mk_res(flush_kind, ERR_NONE, 8'd0, line_r, sub_floor16(col_r, tlen_r),
                        tstart_r, tlen_r);
    eof_res    = mk_res(KIND_EOF, ERR_NONE, 8'd0, line_r, col_r, 32'd0, 16'd0);
    idle_res   = '0;

    if (q_item.op == OP_END) begin
      if (mode_r == MODE_IDENT || mode_r == MODE_NUMBER) begin
        r0    = flush_res;
        r1    = eof_res;
        n_res = 2'd2;
      end else if (mode_r == MODE_STRING) begin
        r0    = mk_res(KIND_ERROR, ERR_UNTERM, 8'd0, line_r, col_r, 32'd0, 16'd0);
        r1    = eof_res;
        n_res = 2'd2;
      end else begin
        r0    = eof_res;
        n_res = 2'd1;
      end
      mode_nxt = MODE_DONE;
    end else begin
      case (mode_r)
        MODE_COMMENT: begin
          if (q_item.cls == CL_NEWLINE) begin
            do_idle = 1'b1;
          end else begin
            col_nxt = col_inc;
            off_nxt = off_inc;
          end
        end
        MODE_IDENT, MODE_NUMBER: begin
          if ((mode_r == MODE_IDENT) ? ident_more : (q_item.cls == CL_DIGIT)) begin
            tlen_nxt = sat16_inc(tlen_r);
            col_nxt  = col_inc;
            off_nxt  = off_inc;
          end else begin
            flush_hit = 1'b1;
            do_idle   = 1'b1;
          end
        end
        MODE_STRING: begin
          col_nxt = col_inc;
          off_nxt = off_inc;
          if (q_item.cls == CL_QUOTE) begin
            // column quirk: text length taken off the column after the close quote
            r0       = mk_res(KIND_STRING, ERR_NONE, 8'd0, line_r,
                              sub_floor16(col_inc, tlen_r), tstart_r, tlen_r);
            n_res    = 2'd1;
            mode_nxt = MODE_IDLE;
          end else begin
            if (q_item.cls == CL_NEWLINE) begin
              line_nxt = sat16_inc(line_r);
            end
            tlen_nxt = sat16_inc(tlen_r);
          end
        end
        MODE_DONE: begin
          mode_nxt = MODE_DONE;
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      if (do_idle) begin
        mode_nxt = MODE_IDLE;
        off_nxt  = off_inc;
        if (q_item.cls == CL_NEWLINE) begin
          line_nxt = sat16_inc(line_r);
          col_nxt  = 16'd1;
        end else begin
          col_nxt = col_inc;
          case (q_item.cls)
            CL_SPACE: ;
            CL_HASH: mode_nxt = MODE_COMMENT;
            CL_IDSTART, CL_DIGIT: begin
              mode_nxt   = (q_item.cls == CL_DIGIT) ? MODE_NUMBER : MODE_IDENT;
              tstart_nxt = off_r;
              tlen_nxt   = 16'd1;
            end
            CL_QUOTE: begin
              mode_nxt   = MODE_STRING;
              tstart_nxt = off_inc;
              tlen_nxt   = 16'd0;
            end
            CL_PUNCT: begin
              idle_emit = 1'b1;
              idle_res  = mk_res(q_item.punct_kind, ERR_NONE, 8'd0, line_r,
                                 sub_floor16(col_inc, 16'd1), off_r, 16'd1);
            end
            default: begin
              // stray '+' and every other byte that cannot open a token
              idle_emit = 1'b1;
              idle_res  = mk_res(KIND_ERROR, ERR_UNEXPECTED, q_item.source_byte, line_r,
                                 col_inc, 32'd0, 16'd0);
            end
          endcase
        end
      end

      if (flush_hit) begin
        r0    = flush_res;
        r1    = idle_res;
        n_res = idle_emit ? 2'd2 : 2'd1;
      end else if (idle_emit) begin
        r0    = idle_res;
        n_res = 2'd1;
      end
    end

    r0.last = (n_res == 2'd1);
    r1.last = 1'b1;
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    if (pend_valid_r && can_load) begin
      out_nxt        = pend_r;
      out_valid_nxt  = 1'b1;
      pend_valid_nxt = 1'b0;
    end else if (q_pop) begin
      out_nxt        = r0;
      out_valid_nxt  = (n_res != 2'd0);
      pend_nxt       = r1;
      pend_valid_nxt = (n_res == 2'd2);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      line_r       <= 16'd1;
      col_r        <= 16'd1;
      off_r        <= '0;
      tstart_r     <= '0;
      tlen_r       <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        mode_r   <= mode_nxt;
        line_r   <= line_nxt;
        col_r    <= col_nxt;
        off_r    <= off_nxt;
        tstart_r <= tstart_nxt;
        tlen_r   <= tlen_nxt;
      end
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  `CLT_ASSERT_ALWAYS(a_pend_behind_out, !pend_valid_r || out_valid_r, "second result without first")
  `CLT_ASSERT_NEXT(a_done_sticks, mode_r == MODE_DONE, mode_r == MODE_DONE, "left done mode")
  `CLT_ASSERT_ALWAYS(a_line_nonzero, (line_r != 16'd0) && (col_r != 16'd0), "line or column zero")

endmodule

// ===== design/config_language_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// config_language_tokenizer_top
// Streaming tokenizer for a small configuration language.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per source byte (op = byte), closed by op = end.
//   out_* : token descriptors (kind, line, column, text offset and length);
//           last marks the final result of an input transaction.
//   Each input gives zero, one or two results. A byte is classified on
//   acceptance and queued (4 entries); the scanner pops it once no second
//   result is pending and the output register can load, and registers its
//   first result, so a result passes the queue and then the output register.
//   Sustained rate is one byte per cycle while out_ready stays high; an item
//   with two results holds the scanner until the second is loaded.
//   Reset (rst_n low, synchronous) empties the queue and output register,
//   returns to line 1, column 1, offset 0. in_ready is low during reset.
//   When out_ready is low the output register holds, the queue fills, and
//   in_ready drops once it is full; nothing is dropped.
// ----------------------------------------------------------------------------
module config_language_tokenizer_top
  import clt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  clt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output clt_out_t out_data
);

  logic      q_push, q_pop, q_full, q_empty;
  clt_item_t push_item, head_item;

  clt_front u_front (
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  clt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  clt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (head_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
